>>> rtl/fct_pkg.sv
// Shared types, constants and helpers of the Fermi confinement term pipeline.
package fct_pkg;

    localparam int GSQ_W  = 32;
    localparam int REG_W  = 32;
    localparam int OUT_W  = 48;
    localparam int QBITS  = 17;
    localparam int SQ_N   = 10;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_CUTOFF    = 2'd0;
    localparam logic [IDX_W-1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH_INV = 2'd2;

    localparam logic [REG_W-1:0] CUTOFF_RST    = 32'd0;
    localparam logic [REG_W-1:0] AMPLITUDE_RST = 32'd0;
    localparam logic [REG_W-1:0] WIDTH_INV_RST = 32'd65536;

    localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
    localparam logic [31:0] RECIP3      = 32'hAAAA_AAAB;
    localparam logic [64:0] CLAMP_LIMIT = 65'd429496729600;
    localparam logic [16:0] FP_ONE      = 17'h1_0000;
    localparam logic [47:0] NUM_NEG     = 48'h8000_0000_0000;
    localparam logic [OUT_W-1:0] OUT_MAX = 48'hFFFF_FFFF_FFFF;

    // Per-item sideband that travels with every stage.
    typedef struct packed {
        logic              valid;
        logic              dis;
        logic              neg;
        logic              clamp;
        logic [GSQ_W-1:0]  gsq;
    } fct_side_t;

    // Q0.31 product rounding: (p + 2^30) >> 31.
    function automatic logic [31:0] rnd31(input logic [63:0] p);
        logic [64:0] s;
        s = {1'b0, p} + 65'h4000_0000;
        return s[62:31];
    endfunction

endpackage

>>> rtl/fct_exp.sv
// Pipelined exp(-z*1024) in Q0.31: Taylor series in four stages, then ten squarings.
module fct_exp
    import fct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [31:0] z,
    input  fct_side_t   side_in,
    output logic [31:0] e,
    output fct_side_t   side_out
);

    localparam int NST = 4 + SQ_N;

    fct_side_t   side_reg  [0:NST-1];
    fct_side_t   side_next [0:NST-1];
    logic [31:0] z_reg  [0:3];
    logic [31:0] z_next [0:3];
    logic [63:0] pr_reg  [0:NST-1];
    logic [63:0] pr_next [0:NST-1];

    always_comb
    begin
        logic [31:0] h0;
        logic [31:0] x;
        logic [32:0] xp1;
        logic [31:0] h;
        logic [32:0] z2;
        z2 = {1'b0, z} + 33'd2;
        h0 = ONE_Q31 - {2'b0, z2[31:2]};
        side_next[0] = side_in;
        z_next[0]    = z;
        pr_next[0]   = 64'(z) * 64'(h0);
        // divide by three through the reciprocal
        x   = rnd31(pr_reg[0]);
        xp1 = {1'b0, x} + 33'd1;
        side_next[1] = side_reg[0];
        z_next[1]    = z_reg[0];
        pr_next[1]   = {31'b0, xp1} * {32'b0, RECIP3};
        h = ONE_Q31 - {1'b0, pr_reg[1][63:33]};
        side_next[2] = side_reg[1];
        z_next[2]    = z_reg[1];
        pr_next[2]   = 64'(z_reg[1]) * 64'(h);
        x   = rnd31(pr_reg[2]);
        xp1 = {1'b0, x} + 33'd1;
        h   = ONE_Q31 - xp1[32:1];
        side_next[3] = side_reg[2];
        z_next[3]    = z_reg[2];
        pr_next[3]   = 64'(z_reg[2]) * 64'(h);
        // first squaring follows the last series term
        h = ONE_Q31 - rnd31(pr_reg[3]);
        side_next[4] = side_reg[3];
        pr_next[4]   = 64'(h) * 64'(h);
        for (int k = 5; k < NST; k++)
        begin
            h            = rnd31(pr_reg[k-1]);
            side_next[k] = side_reg[k-1];
            pr_next[k]   = 64'(h) * 64'(h);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                pr_reg[k] <= pr_next[k];
            end
            for (int k = 0; k < 4; k++)
            begin
                z_reg[k] <= z_next[k];
            end
        end
    end

    assign e        = rnd31(pr_reg[NST-1]);
    assign side_out = side_reg[NST-1];

endmodule

>>> rtl/fct_div.sv
// Restoring divider, one quotient bit per stage, giving the Fermi occupation fp.
module fct_div
    import fct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [31:0] e,
    input  fct_side_t   side_in,
    output logic [16:0] fp,
    output fct_side_t   side_out
);

    fct_side_t   side_reg  [0:QBITS];
    fct_side_t   side_next [0:QBITS];
    logic [47:0] r_reg    [0:QBITS];
    logic [47:0] r_next   [0:QBITS];
    logic [32:0] den_reg  [0:QBITS];
    logic [32:0] den_next [0:QBITS];
    logic [16:0] q_reg    [0:QBITS];
    logic [16:0] q_next   [0:QBITS];

    always_comb
    begin
        logic [32:0] den;
        logic [48:0] trial;
        logic        ge;
        den = {1'b0, ONE_Q31} + {1'b0, e};
        side_next[0] = side_in;
        den_next[0]  = den;
        q_next[0]    = '0;
        // round half up: add half the divisor to the dividend
        if (side_in.neg)
        begin
            r_next[0] = NUM_NEG + {16'b0, den[32:1]};
        end
        else
        begin
            r_next[0] = {e, 16'b0} + {16'b0, den[32:1]};
        end
        for (int i = 0; i < QBITS; i++)
        begin
            trial = 49'(den_reg[i]) << (QBITS - 1 - i);
            ge    = ({1'b0, r_reg[i]} >= trial);
            side_next[i+1] = side_reg[i];
            den_next[i+1]  = den_reg[i];
            r_next[i+1]    = ge ? 48'({1'b0, r_reg[i]} - trial) : r_reg[i];
            q_next[i+1]    = q_reg[i] | (ge ? (17'd1 << (QBITS - 1 - i)) : 17'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QBITS; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i <= QBITS; i++)
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QBITS; i++)
            begin
                r_reg[i]   <= r_next[i];
                den_reg[i] <= den_next[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    // beyond the clamp limit, force fp to one (negative side) or zero
    always_comb
    begin
        if (side_reg[QBITS].clamp)
        begin
            fp = side_reg[QBITS].neg ? FP_ONE : 17'd0;
        end
        else
        begin
            fp = q_reg[QBITS];
        end
    end

    assign side_out = side_reg[QBITS];

endmodule

>>> rtl/fct_out.sv
// Confinement factor, term and derivative products with saturation; holds the output register.
module fct_out
    import fct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [16:0]      fp,
    input  fct_side_t        side_in,
    input  logic [REG_W-1:0] amplitude,
    input  logic [REG_W-1:0] width_inverse,
    output logic             out_valid,
    output logic [OUT_W-1:0] conf_term,
    output logic [OUT_W-1:0] conf_deriv,
    output logic             saturated
);

    fct_side_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    logic [47:0] f1_reg;
    logic [16:0] fp1_reg;
    logic [63:0] pa2_reg;
    logic [47:0] pb2_reg;
    logic [48:0] pc2_reg;
    logic [32:0] pd2_reg;
    logic [33:0] twof2_reg, twof3_reg, twof4_reg, twof5_reg, twof6_reg, twof7_reg;
    logic [48:0] term3_reg, term4_reg, term5_reg, term6_reg, term7_reg;
    logic [47:0] g3_reg;
    logic [63:0] ha4_reg;
    logic [47:0] hb4_reg;
    logic [48:0] h5_reg;
    logic [63:0] da6_reg;
    logic [48:0] db6_reg;
    logic [65:0] d7_reg;
    logic        valid_reg;
    logic [OUT_W-1:0] term_reg, deriv_reg;
    logic        sat_reg;

    logic [47:0] f_next;
    logic [33:0] twof_next;
    logic [80:0] term_sum;
    logic [64:0] g_sum;
    logic [80:0] h_sum;
    logic [81:0] d_sum;
    logic [66:0] deriv_sum;
    logic        term_sat, deriv_sat;
    logic [OUT_W-1:0] term_next, deriv_next;
    logic        sat_next;
    logic [48:0] f_round;

    always_comb
    begin
        f_next    = 48'(amplitude) * 48'(FP_ONE - fp);
        f_round   = {1'b0, f1_reg} + 49'd16384;
        twof_next = f_round[48:15];
        term_sum  = {pb2_reg, 32'b0} + 81'(pa2_reg) + 81'h8000_0000;
        g_sum     = {pd2_reg, 32'b0} + 65'(pc2_reg) + 65'h8000;
        h_sum     = {hb4_reg, 32'b0} + 81'(ha4_reg) + 81'h8000_0000;
        d_sum     = {db6_reg, 32'b0} + 82'(da6_reg) + 82'h8000;
        deriv_sum = 67'(d7_reg) + 67'(twof7_reg);
        term_sat  = term7_reg[48];
        deriv_sat = |deriv_sum[66:48];
        if (s7_reg.dis)
        begin
            term_next  = '0;
            deriv_next = '0;
            sat_next   = 1'b0;
        end
        else
        begin
            term_next  = term_sat ? OUT_MAX : term7_reg[47:0];
            deriv_next = deriv_sat ? OUT_MAX : deriv_sum[47:0];
            sat_next   = term_sat | deriv_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            s2_reg    <= '0;
            s3_reg    <= '0;
            s4_reg    <= '0;
            s5_reg    <= '0;
            s6_reg    <= '0;
            s7_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_reg    <= side_in;
            s2_reg    <= s1_reg;
            s3_reg    <= s2_reg;
            s4_reg    <= s3_reg;
            s5_reg    <= s4_reg;
            s6_reg    <= s5_reg;
            s7_reg    <= s6_reg;
            valid_reg <= s7_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg    <= f_next;
            fp1_reg   <= fp;
            pa2_reg   <= 64'(s1_reg.gsq) * 64'(f1_reg[31:0]);
            pb2_reg   <= 48'(s1_reg.gsq) * 48'(f1_reg[47:32]);
            pc2_reg   <= 49'(f1_reg[31:0]) * 49'(fp1_reg);
            pd2_reg   <= 33'(f1_reg[47:32]) * 33'(fp1_reg);
            twof2_reg <= twof_next;
            term3_reg <= term_sum[80:32];
            g3_reg    <= g_sum[63:16];
            twof3_reg <= twof2_reg;
            ha4_reg   <= 64'(s3_reg.gsq) * 64'(g3_reg[31:0]);
            hb4_reg   <= 48'(s3_reg.gsq) * 48'(g3_reg[47:32]);
            term4_reg <= term3_reg;
            twof4_reg <= twof3_reg;
            h5_reg    <= h_sum[80:32];
            term5_reg <= term4_reg;
            twof5_reg <= twof4_reg;
            da6_reg   <= 64'(width_inverse) * 64'(h5_reg[31:0]);
            db6_reg   <= 49'(width_inverse) * 49'(h5_reg[48:32]);
            term6_reg <= term5_reg;
            twof6_reg <= twof5_reg;
            d7_reg    <= d_sum[81:16];
            term7_reg <= term6_reg;
            twof7_reg <= twof6_reg;
            term_reg  <= term_next;
            deriv_reg <= deriv_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid  = valid_reg;
    assign conf_term  = term_reg;
    assign conf_deriv = deriv_reg;
    assign saturated  = sat_reg;

endmodule

>>> rtl/fermi_confinement_term_top.sv
// Top level of the Fermi-smoothed confinement term pipeline with configuration registers.
// Throughput: one item per cycle; every stage holds one item and the whole pipe
//   advances whenever the output register is empty or being taken.
// Reset (rst_n low, asynchronous): all stage valid bits clear, cutoff_energy = 0,
//   amplitude = 0, width_inverse = 1.0; the block is ready at once after release.
module fermi_confinement_term_top
    import fct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration write port
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    // input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // [31:0] gsq
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // [47:0] conf_term, [95:48] conf_deriv
    output logic [0:0]       m_axis_tuser    // [0] saturated
);

    logic [REG_W-1:0] cutoff_reg, amplitude_reg, width_inv_reg;

    // Hold the register bank; unknown indexes drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg    <= CUTOFF_RST;
            amplitude_reg <= AMPLITUDE_RST;
            width_inv_reg <= WIDTH_INV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CUTOFF:    cutoff_reg    <= cfg_data;
                REG_AMPLITUDE: amplitude_reg <= cfg_data;
                REG_WIDTH_INV: width_inv_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Global advance: the pipe moves as one whenever the output slot frees up.
    logic en;
    logic out_valid;
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid;

    // Stage 1: distance from twice the cutoff, its magnitude and sign.
    fct_side_t       s1_reg, s1_next;
    logic [32:0]     m1_reg, m1_next;
    logic signed [34:0] d2;

    always_comb
    begin
        d2 = $signed({3'b0, s_axis_tdata})
           - $signed({{2{cutoff_reg[31]}}, cutoff_reg, 1'b0});
        s1_next.valid = s_axis_tvalid;
        s1_next.gsq   = s_axis_tdata;
        s1_next.dis   = cutoff_reg[31] || (cutoff_reg == '0);
        s1_next.neg   = d2[34];
        s1_next.clamp = 1'b0;
        m1_next       = d2[34] ? 33'(-d2) : d2[32:0];
    end

    // Stage 2: scale by the inverse width, |arg| = P / 2^33.
    fct_side_t   s2_reg;
    logic [64:0] p2_reg;

    // Stage 3: clamp decision and exp argument z = |arg|/1024 in Q0.31.
    fct_side_t   s3_reg, s3_next;
    logic [31:0] z3_reg, z3_next;
    logic [65:0] z_sum;

    always_comb
    begin
        z_sum         = {1'b0, p2_reg} + 66'd2048;
        z3_next       = z_sum[43:12];
        s3_next       = s2_reg;
        s3_next.clamp = (p2_reg > CLAMP_LIMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= m1_next;
            p2_reg <= 65'(m1_reg) * 65'(width_inv_reg);
            z3_reg <= z3_next;
        end
    end

    // exp(-|arg|), then the occupation divide, then the output products.
    logic [31:0] e_val;
    fct_side_t   exp_side;
    logic [16:0] fp_val;
    fct_side_t   div_side;
    logic [OUT_W-1:0] term_val, deriv_val;
    logic        sat_val;

    fct_exp u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .z        (z3_reg),
        .side_in  (s3_reg),
        .e        (e_val),
        .side_out (exp_side)
    );

    fct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .e        (e_val),
        .side_in  (exp_side),
        .fp       (fp_val),
        .side_out (div_side)
    );

    fct_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .fp            (fp_val),
        .side_in       (div_side),
        .amplitude     (amplitude_reg),
        .width_inverse (width_inv_reg),
        .out_valid     (out_valid),
        .conf_term     (term_val),
        .conf_deriv    (deriv_val),
        .saturated     (sat_val)
    );

    assign m_axis_tdata = {deriv_val, term_val};
    assign m_axis_tuser = sat_val;

endmodule

>>> verif/testbench.sv
// Self-checking testbench of the Fermi confinement term pipeline.
`timescale 1ns / 1ps

module testbench;
    import fct_pkg::*;

    localparam int LATENCY = 43;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;   // [31:0] gsq
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [95:0]      m_axis_tdata;   // [47:0] conf_term, [95:48] conf_deriv
    logic [0:0]       m_axis_tuser;   // [0] saturated

    typedef struct packed {
        logic [47:0] term;
        logic [47:0] deriv;
        logic        sat;
    } conf_result_t;

    fermi_confinement_term_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Own copy of the configuration registers.
    logic [31:0] cut_q, amp_q, winv_q;

    logic [31:0]  gsq_pending[$];
    conf_result_t result_due[$];
    int           mismatches;
    int           received;
    int           hold_off;     // cycles left of a forced receiver stall
    bit           stim_done;
    bit           in_taken;     // input item accepted at the last rising edge

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rounded product a*b/2^s; all-ones when it overflows 64 bits.
    function automatic logic [63:0] prod_round(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
        p = p >> s;
        if (p[127:64] != 0)
            return '1;
        return p[63:0];
    endfunction

    function automatic logic [63:0] q31(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'h4000_0000) >> 31;
    endfunction

    function automatic logic [63:0] decay_q31(logic [63:0] z);
        logic [63:0] h;
        h = 64'h8000_0000 - ((z + 2) >> 2);
        h = 64'h8000_0000 - (q31(z, h) + 1) / 3;
        h = 64'h8000_0000 - ((q31(z, h) + 1) >> 1);
        h = 64'h8000_0000 - q31(z, h);
        for (int i = 0; i < SQ_N; i++)
            h = q31(h, h);
        return h;
    endfunction

    function automatic conf_result_t confine(logic [31:0] gsq);
        conf_result_t r;
        logic signed [63:0] ecut, d2;
        logic [63:0] m, p, fp, f, e, den, g, h, d, twof;
        r = '0;
        ecut = $signed({{32{cut_q[31]}}, cut_q});
        if (ecut <= 0)
            return r;
        d2 = $signed({32'd0, gsq}) - 2 * ecut;
        m = (d2 < 0) ? -d2 : d2;
        p = m * {32'd0, winv_q};
        if (p > (64'd50 << 33))
            fp = (d2 > 0) ? 64'd0 : 64'd65536;
        else
        begin
            e = decay_q31((p + 2048) >> 12);
            den = 64'h8000_0000 + e;
            if (d2 >= 0)
                fp = ((e << 16) + (den >> 1)) / den;
            else
                fp = ((64'h8000_0000 << 16) + (den >> 1)) / den;
        end
        f = {32'd0, amp_q} * (64'd65536 - fp);
        m = prod_round({32'd0, gsq}, f, 32);
        if (m > {16'd0, OUT_MAX})
        begin
            r.term = OUT_MAX;
            r.sat = 1'b1;
        end
        else
            r.term = m[47:0];
        g = prod_round(f, fp, 16);
        h = prod_round({32'd0, gsq}, g, 32);
        d = prod_round(h, {32'd0, winv_q}, 16);
        twof = (f + 16384) >> 15;
        if (d > {16'd0, OUT_MAX} || twof + d > {16'd0, OUT_MAX})
        begin
            r.deriv = OUT_MAX;
            r.sat = 1'b1;
        end
        else
            r.deriv = twof + d;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Record the input handshake at the edge where it happens.
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Driver: offer items from the pending queue, with random gaps.
    int send_gap;
    bit burst_mode;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                result_due.push_back(confine(s_axis_tdata));
                void'(gsq_pending.pop_front());
                send_gap = burst_mode ? 0 : gap_len();
            end
            if (in_taken || !s_axis_tvalid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (gsq_pending.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= gsq_pending[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure: random stalls, plus a forced long hold-off.
    int recv_gap;
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            m_axis_tready <= 1'b0;
        end
        else if (burst_mode)
            m_axis_tready <= 1'b1;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            recv_gap = gap_len();
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compare each result item against the oldest expectation.
    always @(posedge clk)
    begin
        conf_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            received++;
            if (result_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_axis_tdata);
            end
            else
            begin
                want = result_due.pop_front();
                if (m_axis_tdata[47:0] !== want.term || m_axis_tdata[95:48] !== want.deriv
                    || m_axis_tuser[0] !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp term %h deriv %h sat %b, got %h %h %b",
                                 want.term, want.deriv, want.sat, m_axis_tdata[47:0],
                                 m_axis_tdata[95:48], m_axis_tuser[0]);
                end
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CUTOFF)
            cut_q = val;
        else if (idx == REG_AMPLITUDE)
            amp_q = val;
        else if (idx == REG_WIDTH_INV)
            winv_q = val;
    endtask

    // Block until every queued item has been sent and answered.
    task automatic drain();
        while (gsq_pending.size() > 0 || result_due.size() > 0 || s_axis_tvalid)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Gsq near the Fermi edge 2*cutoff, where the exponential matters.
    function automatic logic [31:0] edge_gsq();
        logic [63:0] c2;
        logic signed [63:0] v;
        c2 = {31'd0, cut_q, 1'b0};
        v = $signed(c2) + $signed({{32{1'b0}}, $urandom}) % (64'd1 << $urandom_range(4, 24))
            - (64'd1 << 23);
        if (v < 0)
            v = 0;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic [31:0] any_gsq();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0010_0000);
            default: return edge_gsq();
        endcase
    endfunction

    logic [31:0] cut_set[6] = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                               32'h0010_0000, 32'h0100_0000, 32'h0003_8000};
    logic [31:0] amp_set[5] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                               32'h0064_0000, 32'h0002_0000};
    logic [31:0] winv_set[6] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                32'h0000_0000, 32'h0000_4000, 32'h0010_0000};

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cut_q = CUTOFF_RST;
        amp_q = AMPLITUDE_RST;
        winv_q = WIDTH_INV_RST;
        mismatches = 0;
        received = 0;
        hold_off = 0;
        send_gap = 0;
        recv_gap = 0;
        burst_mode = 0;
        stim_done = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Disabled term at reset values, then with a negative cutoff.
        gsq_pending.push_back(32'd0);
        gsq_pending.push_back(32'hFFFF_FFFF);
        gsq_pending.push_back(32'h0002_0000);
        drain();
        write_reg(REG_CUTOFF, 32'h8000_0000);
        write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
        gsq_pending.push_back(32'h1234_5678);
        gsq_pending.push_back(32'hFFFF_FFFF);
        drain();

        // Directed: moderate setting, large args both ways, exact edge, zero width.
        write_reg(REG_CUTOFF, 32'h0001_0000);
        write_reg(REG_AMPLITUDE, 32'h0001_0000);
        write_reg(REG_WIDTH_INV, 32'h0001_0000);
        gsq_pending.push_back(32'd0);
        gsq_pending.push_back(32'h0002_0000);
        gsq_pending.push_back(32'h0001_8000);
        gsq_pending.push_back(32'h0002_8000);
        gsq_pending.push_back(32'h0080_0000);
        gsq_pending.push_back(32'hFFFF_FFFF);
        drain();
        write_reg(REG_WIDTH_INV, 32'd0);
        gsq_pending.push_back(32'h0005_0000);
        gsq_pending.push_back(32'hFFFF_FFFF);
        drain();
        write_reg(REG_CUTOFF, 32'h7FFF_FFFF);
        write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
        write_reg(REG_WIDTH_INV, 32'hFFFF_FFFF);
        gsq_pending.push_back(32'hFFFF_FFFF);
        gsq_pending.push_back(32'hFFFF_FFFE);
        gsq_pending.push_back(32'd0);
        gsq_pending.push_back(32'h5555_5555);
        drain();

        // Random phases over register settings, extremes included.
        for (int ph = 0; ph < 27; ph++)
        begin
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_CUTOFF, $urandom);
            else
                write_reg(REG_CUTOFF, cut_set[$urandom_range(0, 5)]);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_AMPLITUDE, $urandom);
            else
                write_reg(REG_AMPLITUDE, amp_set[$urandom_range(0, 4)]);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_WIDTH_INV, $urandom);
            else
                write_reg(REG_WIDTH_INV, winv_set[$urandom_range(0, 5)]);
            if (ph == 5)
                write_reg(REG_UNUSED, $urandom);
            if (ph == 8)
            begin
                // Stall the receiver long enough to fill the pipe and back up input.
                burst_mode = 1;
                hold_off = 150;
            end
            if (ph == 10)
                burst_mode = 0;
            for (int i = 0; i < 50; i++)
                gsq_pending.push_back(any_gsq());
            drain();
        end

        stim_done = 1;
        repeat (LATENCY + 10) @(negedge clk);
        $display("covered %0d result items over 32 register settings, incl. disabled,",
                 received);
        $display("clamped, zero-width and saturating cases, with random stalls both sides");
        if (mismatches == 0 && result_due.size() == 0)
            $display("fermi_confinement_term_top test passed");
        else
            $display("fermi_confinement_term_top test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("fermi_confinement_term_top test failed");
        $finish;
    end
endmodule
